@@ rtl/asr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the serial converter readout.
package asr_pkg;

	localparam int CODE_BITS   = 24;
	localparam int MAX_SAMPLES = 1024;

	localparam int HALF_W   = 8;
	localparam int TMO_W    = 24;
	localparam int ATT_W    = 4;
	localparam int SAMP_W   = 11;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;
	localparam int VAL_W    = CODE_BITS + 1;
	localparam int RETRY_W  = 16;
	localparam int SUM_W    = CODE_BITS + SAMP_W;
	localparam int MAG_W    = SUM_W - 1;
	localparam int BIT_W    = $clog2(CODE_BITS + 1);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TARE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_AVG  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd1;
	localparam logic [STAT_W-1:0] ST_LINK    = 2'd2;
	localparam logic [STAT_W-1:0] ST_FAILED  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_HALF    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 4'd3;

	localparam logic [HALF_W-1:0] HALF_RST    = 8'd40;
	localparam logic [TMO_W-1:0]  TIMEOUT_RST = 24'd500000;
	localparam logic [ATT_W-1:0]  ATTEMPT_RST = 4'd8;
	localparam logic [SAMP_W-1:0] SAMPLES_RST = 11'd16;

	typedef struct packed {
		logic [HALF_W-1:0] half_period_ticks;
		logic [TMO_W-1:0]  ready_timeout_ticks;
		logic [ATT_W-1:0]  read_attempts;
		logic [SAMP_W-1:0] sample_count;
	} cfg_t;

endpackage

@@ rtl/asr_in_if.sv @@
`timescale 1ns / 1ps
// Tick channel carrying the command and the sampled DOUT level.
interface asr_in_if;
	logic                        valid;
	logic                        ready;
	logic [asr_pkg::CMD_W-1:0]   cmd;
	logic                        dout_level;

	modport source (output valid, output cmd, output dout_level, input ready);
	modport sink (input valid, input cmd, input dout_level, output ready);
endinterface

@@ rtl/asr_out_if.sv @@
`timescale 1ns / 1ps
// Result channel carrying the pin level, status and value of one tick.
interface asr_out_if;
	logic                               valid;
	logic                               ready;
	logic                               sclk_level;
	logic                               busy_res;
	logic                               done_res;
	logic [asr_pkg::STAT_W-1:0]         status;
	logic signed [asr_pkg::VAL_W-1:0]   result_value;
	logic [asr_pkg::RETRY_W-1:0]        retry_total;

	modport source (output valid, output sclk_level, output busy_res, output done_res,
		output status, output result_value, output retry_total, input ready);
	modport sink (input valid, input sclk_level, input busy_res, input done_res,
		input status, input result_value, input retry_total, output ready);
endinterface

@@ rtl/asr_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel carrying a register index and write data.
interface asr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [asr_pkg::CFG_IDX_W-1:0]     index;
	logic [asr_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/asr_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file of the serial converter readout.
module asr_cfg (
	input  logic           clk,
	input  logic           arst_n,
	asr_cfg_if.sink        cfg_ch,
	output asr_pkg::cfg_t  cfg
);
	import asr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg          = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks   <= HALF_RST;
			cfg_q.ready_timeout_ticks <= TIMEOUT_RST;
			cfg_q.read_attempts       <= ATTEMPT_RST;
			cfg_q.sample_count        <= SAMPLES_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_HALF:    cfg_q.half_period_ticks   <= cfg_ch.data[HALF_W-1:0];
				REG_TIMEOUT: cfg_q.ready_timeout_ticks <= cfg_ch.data[TMO_W-1:0];
				REG_ATTEMPT: cfg_q.read_attempts       <= cfg_ch.data[ATT_W-1:0];
				REG_SAMPLES: cfg_q.sample_count        <= cfg_ch.data[SAMP_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/asr_div.sv @@
`timescale 1ns / 1ps
// Iterative restoring divider producing the truncated mean, one quotient bit per cycle.
module asr_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [asr_pkg::SUM_W-1:0]   dividend,
	input  logic [asr_pkg::SAMP_W-1:0]         divisor,
	output logic                               done,
	output logic signed [asr_pkg::VAL_W-1:0]   quotient
);
	import asr_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic                  neg_q;
	logic [MAG_W-1:0]      mag_q;
	logic [SAMP_W-1:0]     rem_q;
	logic [SAMP_W-1:0]     den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;

	logic [SUM_W-1:0]      abs_in;
	logic [SAMP_W:0]       rem_sh;
	logic                  ge;
	logic [SAMP_W:0]       rem_sub;
	logic [VAL_W-1:0]      mag_lo;

	assign abs_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign rem_sh  = {rem_q, mag_q[MAG_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign mag_lo  = mag_q[VAL_W-1:0];

	assign done     = done_q;
	assign quotient = neg_q ? signed'(VAL_W'(-mag_lo)) : signed'(mag_lo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= abs_in[MAG_W-1:0];
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[MAG_W-2:0], ge};
			rem_q <= ge ? rem_sub[SAMP_W-1:0] : rem_sh[SAMP_W-1:0];
		end
	end
endmodule

@@ rtl/adc_serial_readout_with_retry.sv @@
`timescale 1ns / 1ps
// Top level of the serial converter readout: tick sequencer, output register and mean unit.
//
// Each transaction on cmd_ch is one clock tick of the converter interface and yields exactly
// one transaction on res_ch, so the block normally takes one tick per cycle. The tick that
// completes a tare or an averaged read is the exception: the truncated mean is formed by one
// shared restoring divider that retires one quotient bit per cycle, so that tick holds cmd_ch
// ready low until the divider is done and its result appears; then the next tick is taken.
// Ready also stays low while a finished result waits in the output register and res_ch stalls.
// Register writes take effect on the next cycle; indexes beyond the register list are ignored.
module adc_serial_readout_with_retry (
	input  logic      clk,
	input  logic      arst_n,
	asr_in_if.sink    cmd_ch,
	asr_out_if.source res_ch,
	asr_cfg_if.sink   cfg_ch
);
	import asr_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_WAIT = 3'd1;
	localparam logic [2:0] PH_HIGH = 3'd2;
	localparam logic [2:0] PH_LOW  = 3'd3;
	localparam logic [2:0] PH_DIV  = 3'd4;

	cfg_t cfg;

	logic [2:0]               phase_q, phase_d;
	logic [CMD_W-1:0]         act_q, act_d;
	logic [TMO_W-1:0]         tick_q, tick_d;
	logic [BIT_W-1:0]         bit_q, bit_d;
	logic [CODE_BITS-1:0]     shift_q, shift_d;
	logic [ATT_W-1:0]         att_q, att_d;
	logic [SAMP_W-1:0]        samp_q, samp_d;
	logic signed [SUM_W-1:0]  sum_q, sum_d;
	logic signed [CODE_BITS-1:0] offset_q;
	logic [RETRY_W-1:0]       retry_q, retry_d;
	logic                     clk_q, clk_d;
	logic                     pend_sclk_q;

	logic                     out_valid_q;
	logic                     out_sclk_q;
	logic                     out_busy_q;
	logic                     out_done_q;
	logic [STAT_W-1:0]        out_status_q;
	logic signed [VAL_W-1:0]  out_value_q;
	logic [RETRY_W-1:0]       out_retry_q;

	logic                     out_free;
	logic                     accept;
	logic                     div_go;
	logic                     div_done;
	logic signed [VAL_W-1:0]  div_quot;
	logic signed [VAL_W-1:0]  mean_out;

	logic [HALF_W-1:0]        half;
	logic [ATT_W-1:0]         lim;
	logic [SAMP_W-1:0]        nsamp;
	logic [TMO_W-1:0]         tick_inc;
	logic [BIT_W-1:0]         bit_inc;
	logic [ATT_W:0]           att_inc;
	logic [SAMP_W-1:0]        samp_inc;
	logic signed [SUM_W-1:0]  code;
	logic                     word_bad;
	logic                     fail;
	logic [STAT_W-1:0]        fail_kind;
	logic [ATT_W-1:0]         ret_n;
	logic [RETRY_W:0]         ret_sum;
	logic                     fin_done;
	logic [STAT_W-1:0]        fin_status;
	logic signed [VAL_W-1:0]  fin_value;

	asr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	asr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go && accept),
		.dividend (sum_d),
		.divisor  (nsamp),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_free     = !out_valid_q || res_ch.ready;
	assign cmd_ch.ready = (phase_q != PH_DIV) && out_free;
	assign accept       = cmd_ch.valid && cmd_ch.ready;

	assign half  = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
	assign lim   = (cfg.read_attempts == '0) ? ATT_W'(1) : cfg.read_attempts;
	assign nsamp = (cfg.sample_count == '0) ? SAMP_W'(1) :
		(cfg.sample_count > SAMP_W'(MAX_SAMPLES)) ? SAMP_W'(MAX_SAMPLES) : cfg.sample_count;

	assign tick_inc = tick_q + 1'b1;
	assign bit_inc  = bit_q + 1'b1;
	assign att_inc  = {1'b0, att_q} + 1'b1;
	assign samp_inc = samp_q + 1'b1;
	assign code     = SUM_W'(signed'(shift_q));
	assign word_bad = !cmd_ch.dout_level || (shift_q == '0) || (shift_q == '1);

	assign mean_out = (act_q == CMD_TARE) ? div_quot :
		VAL_W'(div_quot - VAL_W'(offset_q));

	always_comb begin
		phase_d    = phase_q;
		act_d      = act_q;
		tick_d     = tick_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		att_d      = att_q;
		samp_d     = samp_q;
		sum_d      = sum_q;
		clk_d      = clk_q;
		fail       = 1'b0;
		fail_kind  = ST_OK;
		ret_n      = '0;
		div_go     = 1'b0;
		fin_done   = 1'b0;
		fin_status = ST_OK;
		fin_value  = '0;

		unique case (phase_q)
			PH_IDLE: begin
				if (cmd_ch.cmd != CMD_TICK) begin
					act_d   = cmd_ch.cmd;
					att_d   = '0;
					samp_d  = '0;
					sum_d   = '0;
					phase_d = PH_WAIT;
					tick_d  = '0;
					bit_d   = '0;
					shift_d = '0;
					clk_d   = 1'b0;
				end
			end
			PH_WAIT: begin
				if (!cmd_ch.dout_level) begin
					phase_d = PH_HIGH;
					tick_d  = '0;
					clk_d   = 1'b1;
				end else if (tick_q >= cfg.ready_timeout_ticks) begin
					fail      = 1'b1;
					fail_kind = ST_TIMEOUT;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_HIGH: begin
				tick_d = tick_inc;
				if (tick_inc >= TMO_W'(half)) begin
					shift_d = {shift_q[CODE_BITS-2:0], cmd_ch.dout_level};
					clk_d   = 1'b0;
					tick_d  = '0;
					phase_d = PH_LOW;
				end
			end
			PH_LOW: begin
				tick_d = tick_inc;
				if (tick_inc >= TMO_W'(half)) begin
					tick_d = '0;
					bit_d  = bit_inc;
					if (bit_inc >= BIT_W'(CODE_BITS)) begin
						if (word_bad) begin
							fail      = 1'b1;
							fail_kind = ST_LINK;
						end else if (act_q == CMD_READ) begin
							phase_d    = PH_IDLE;
							clk_d      = 1'b0;
							fin_done   = 1'b1;
							fin_value  = VAL_W'(code);
						end else begin
							ret_n  = att_q;
							att_d  = '0;
							sum_d  = sum_q + code;
							samp_d = samp_inc;
							if (samp_inc < nsamp) begin
								phase_d = PH_WAIT;
								bit_d   = '0;
								shift_d = '0;
								clk_d   = 1'b0;
							end else begin
								phase_d = PH_DIV;
								clk_d   = 1'b0;
								div_go  = 1'b1;
							end
						end
					end else begin
						clk_d   = 1'b1;
						phase_d = PH_HIGH;
					end
				end
			end
			PH_DIV: ;
			default: ;
		endcase

		if (fail) begin
			if (act_q == CMD_READ) begin
				phase_d    = PH_IDLE;
				clk_d      = 1'b0;
				fin_done   = 1'b1;
				fin_status = fail_kind;
			end else if (att_inc >= {1'b0, lim}) begin
				att_d      = att_inc[ATT_W-1:0];
				ret_n      = lim;
				phase_d    = PH_IDLE;
				clk_d      = 1'b0;
				fin_done   = 1'b1;
				fin_status = ST_FAILED;
			end else begin
				att_d   = att_inc[ATT_W-1:0];
				phase_d = PH_WAIT;
				tick_d  = '0;
				bit_d   = '0;
				shift_d = '0;
				clk_d   = 1'b0;
			end
		end

		ret_sum = {1'b0, retry_q} + (RETRY_W + 1)'(ret_n);
		retry_d = ret_sum[RETRY_W] ? '1 : ret_sum[RETRY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			act_q       <= CMD_TICK;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			att_q       <= '0;
			samp_q      <= '0;
			sum_q       <= '0;
			offset_q    <= '0;
			retry_q     <= '0;
			clk_q       <= 1'b0;
			pend_sclk_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				act_q       <= act_d;
				tick_q      <= tick_d;
				bit_q       <= bit_d;
				shift_q     <= shift_d;
				att_q       <= att_d;
				samp_q      <= samp_d;
				sum_q       <= sum_d;
				retry_q     <= retry_d;
				clk_q       <= clk_d;
				pend_sclk_q <= clk_q;
				out_valid_q <= !div_go;
			end else if (phase_q == PH_DIV && div_done && out_free) begin
				phase_q     <= PH_IDLE;
				out_valid_q <= 1'b1;
				if (act_q == CMD_TARE) begin
					offset_q <= div_quot[CODE_BITS-1:0];
				end
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_sclk_q   <= clk_q;
			out_busy_q   <= (phase_d != PH_IDLE);
			out_done_q   <= fin_done;
			out_status_q <= fin_status;
			out_value_q  <= fin_value;
			out_retry_q  <= retry_d;
		end else if (phase_q == PH_DIV && div_done && out_free) begin
			out_sclk_q   <= pend_sclk_q;
			out_busy_q   <= 1'b0;
			out_done_q   <= 1'b1;
			out_status_q <= ST_OK;
			out_value_q  <= mean_out;
			out_retry_q  <= retry_q;
		end
	end

	assign res_ch.valid        = out_valid_q;
	assign res_ch.sclk_level   = out_sclk_q;
	assign res_ch.busy_res     = out_busy_q;
	assign res_ch.done_res     = out_done_q;
	assign res_ch.status       = out_status_q;
	assign res_ch.result_value = out_value_q;
	assign res_ch.retry_total  = out_retry_q;
endmodule
